// File: design/sbag_pkg.sv
// ----------------------------------------------------------------------------
// sbag_pkg
// Shared constants and types for the shuffle bag core: field widths,
// generator constants, command codes and the sequencer state type.
// ----------------------------------------------------------------------------
package sbag_pkg;

   localparam int SCENE_COUNT_DEF = 16;

   localparam int FUNC_W  = 1;
   localparam int SEED_W  = 32;
   localparam int SCENE_W = 4;
   localparam int REM_W   = 5;

   localparam logic [SEED_W-1:0] XS_ZERO_SUB = 32'h9e37_79b9;
   localparam int XS_SHIFT_A = 13;
   localparam int XS_SHIFT_B = 17;
   localparam int XS_SHIFT_C = 5;

   localparam logic [FUNC_W-1:0] FUNC_DEAL    = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_SHUFFLE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_XS,
      ST_DIV,
      ST_RD_A,
      ST_RD_B,
      ST_WR_A,
      ST_WR_B,
      ST_FINISH,
      ST_DEAL_RD,
      ST_DEAL_DATA,
      ST_RESP
   } state_type;

endpackage

// File: design/sbag_ram.sv
// ----------------------------------------------------------------------------
// sbag_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sbag_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/shuffle_bag_no_repeat_core.sv
// ----------------------------------------------------------------------------
// shuffle_bag_no_repeat_core
// Deals indices 0..SCENE_COUNT-1 in shuffled order without an immediate
// repeat across bags. The order lives in one RAM; a sequencer fills it,
// runs a Fisher-Yates pass with xorshift32 and a bit-serial modulo unit.
// Flow: a deal from a filled bag reads the order RAM in ST_DEAL_RD and
// ST_DEAL_DATA, then ST_RESP registers the response; ST_RESP waits while
// the output is stalled. A refill on a deal adds the fill pass, SCENE_COUNT-1
// swap steps (ST_XS, bit-serial modulo in ST_DIV, ST_RD_A..ST_WR_B), the
// no-repeat check and ST_FINISH; one transaction is in work at a time.
// Reset (synchronous): bag empty, no previous index, no result pending.
// ----------------------------------------------------------------------------
module shuffle_bag_no_repeat_core #(
   parameter int SCENE_COUNT = sbag_pkg::SCENE_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sbag_pkg::FUNC_W-1:0]   req_func,
   input  logic [sbag_pkg::SEED_W-1:0]   req_seed,
   input  logic [sbag_pkg::SEED_W-1:0]   req_entropy,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sbag_pkg::SCENE_W-1:0]  rsp_scene,
   output logic                          rsp_dealt,
   output logic [sbag_pkg::REM_W-1:0]    rsp_remaining
);

   import sbag_pkg::*;

   localparam int IDX_W = $clog2(SCENE_COUNT);
   localparam int CUR_W = $clog2(SCENE_COUNT + 1);
   localparam int RW    = CUR_W + 1;
   localparam int CNT_W = $clog2(SEED_W);

   state_type state_ff, state_in;

   logic [CUR_W-1:0]  cursor_ff, cursor_in;
   logic [IDX_W-1:0]  prev_ff, prev_in;
   logic              prev_valid_ff, prev_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [FUNC_W-1:0] func_ff, func_in;
   logic [SEED_W-1:0] st_ff, st_in;
   logic [SEED_W-1:0] dvd_ff, dvd_in;
   logic [RW-1:0]     r_ff, r_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CUR_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  fill_ff, fill_in;
   logic [IDX_W-1:0]  addr_a_ff, addr_a_in;
   logic [IDX_W-1:0]  addr_b_ff, addr_b_in;
   logic              fix_ff, fix_in;
   logic [IDX_W-1:0]  t_ff, t_in;
   logic [IDX_W-1:0]  scene_ff, scene_in;

   logic [SCENE_W-1:0] rsp_scene_ff, rsp_scene_in;
   logic               rsp_dealt_ff, rsp_dealt_in;
   logic [REM_W-1:0]   rsp_rem_ff, rsp_rem_in;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [IDX_W-1:0]  ram_wr_data;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [IDX_W-1:0]  ram_rd_data;

   logic [SEED_W-1:0] xs_v0, xs_v1, xs_v2, xs_v3;
   logic [RW-1:0]     r_sh, r_mod;
   logic [IDX_W+SCENE_W-1:0] scene_ext;
   logic [CUR_W+REM_W-1:0]   rem_ext;
   logic [CUR_W-1:0]  rem_val;
   logic              req_accept, out_free;

   sbag_ram #(
      .WIDTH (IDX_W),
      .DEPTH (SCENE_COUNT)
   ) u_order_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign xs_v0 = (st_ff == '0) ? XS_ZERO_SUB : st_ff;
   assign xs_v1 = xs_v0 ^ (xs_v0 << XS_SHIFT_A);
   assign xs_v2 = xs_v1 ^ (xs_v1 >> XS_SHIFT_B);
   assign xs_v3 = xs_v2 ^ (xs_v2 << XS_SHIFT_C);

   assign r_sh  = {r_ff[RW-2:0], dvd_ff[SEED_W-1]};
   assign r_mod = (r_sh >= {1'b0, i_ff}) ? (r_sh - {1'b0, i_ff}) : r_sh;

   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      func_in       = func_ff;
      st_in         = st_ff;
      dvd_in        = dvd_ff;
      r_in          = r_ff;
      cnt_in        = cnt_ff;
      i_in          = i_ff;
      fill_in       = fill_ff;
      addr_a_in     = addr_a_ff;
      addr_b_in     = addr_b_ff;
      fix_in        = fix_ff;
      t_in          = t_ff;
      scene_in      = scene_ff;
      rsp_scene_in  = rsp_scene_ff;
      rsp_dealt_in  = rsp_dealt_ff;
      rsp_rem_in    = rsp_rem_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = addr_a_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_addr   = addr_b_ff;
      scene_ext     = {{SCENE_W{1'b0}}, scene_ff};
      rem_val       = '0;
      rem_ext       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               func_in = req_func;
               st_in   = (req_seed == '0) ? req_entropy : req_seed;
               fill_in = '0;
               if ((req_func == FUNC_SHUFFLE) || (cursor_ff >= CUR_W'(SCENE_COUNT))) begin
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_DEAL_RD;
               end
            end
         end
         ST_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = fill_ff;
            ram_wr_data = fill_ff;
            fill_in     = fill_ff + 1'b1;
            if (fill_ff == IDX_W'(SCENE_COUNT - 1)) begin
               i_in     = CUR_W'(SCENE_COUNT);
               state_in = ST_XS;
            end
         end
         ST_XS: begin
            st_in    = xs_v3;
            dvd_in   = xs_v3;
            r_in     = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            r_in   = r_mod;
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SEED_W - 1)) begin
               addr_a_in = IDX_W'(i_ff - 1'b1);
               addr_b_in = r_mod[IDX_W-1:0];
               fix_in    = 1'b0;
               state_in  = ST_RD_A;
            end
         end
         ST_RD_A: begin
            ram_rd_addr = addr_a_ff;
            state_in    = ST_RD_B;
         end
         ST_RD_B: begin
            ram_rd_addr = addr_b_ff;
            t_in        = ram_rd_data;
            state_in    = ST_WR_A;
         end
         ST_WR_A: begin
            if (fix_ff && !(prev_valid_ff && (t_ff == prev_ff))) begin
               state_in = ST_FINISH;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = addr_a_ff;
               ram_wr_data = ram_rd_data;
               state_in    = ST_WR_B;
            end
         end
         ST_WR_B: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_b_ff;
            ram_wr_data = t_ff;
            if (fix_ff) begin
               state_in = ST_FINISH;
            end else if (i_ff > CUR_W'(2)) begin
               i_in     = i_ff - 1'b1;
               state_in = ST_XS;
            end else begin
               fix_in    = 1'b1;
               addr_a_in = '0;
               addr_b_in = IDX_W'(1);
               state_in  = ST_RD_A;
            end
         end
         ST_FINISH: begin
            cursor_in = '0;
            if (func_ff == FUNC_DEAL) begin
               state_in = ST_DEAL_RD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_DEAL_RD: begin
            ram_rd_addr = cursor_ff[IDX_W-1:0];
            state_in    = ST_DEAL_DATA;
         end
         ST_DEAL_DATA: begin
            scene_in = ram_rd_data;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               if (func_ff == FUNC_DEAL) begin
                  cursor_in     = cursor_ff + 1'b1;
                  prev_in       = scene_ff;
                  prev_valid_in = 1'b1;
                  rsp_scene_in  = scene_ext[SCENE_W-1:0];
                  rsp_dealt_in  = 1'b1;
               end else begin
                  rsp_scene_in  = '0;
                  rsp_dealt_in  = 1'b0;
               end
               rem_val      = CUR_W'(SCENE_COUNT) - cursor_in;
               rem_ext      = {{REM_W{1'b0}}, rem_val};
               rsp_rem_in   = rem_ext[REM_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cursor_ff     <= CUR_W'(SCENE_COUNT);
         prev_ff       <= '0;
         prev_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         prev_ff       <= prev_in;
         prev_valid_ff <= prev_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      st_ff        <= st_in;
      dvd_ff       <= dvd_in;
      r_ff         <= r_in;
      cnt_ff       <= cnt_in;
      i_ff         <= i_in;
      fill_ff      <= fill_in;
      addr_a_ff    <= addr_a_in;
      addr_b_ff    <= addr_b_in;
      fix_ff       <= fix_in;
      t_ff         <= t_in;
      scene_ff     <= scene_in;
      rsp_scene_ff <= rsp_scene_in;
      rsp_dealt_ff <= rsp_dealt_in;
      rsp_rem_ff   <= rsp_rem_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scene     = rsp_scene_ff;
   assign rsp_dealt     = rsp_dealt_ff;
   assign rsp_remaining = rsp_rem_ff;

endmodule

// File: tb/sv/sbag_deal_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbag_deal_monitor
// Watches both channels of the shuffle bag core. Every accepted request is run
// through a local model of the bag (identity reload, xorshift32 Fisher-Yates
// pass, no-repeat swap, deal cursor) and the expected response is queued.
// Every accepted response is compared field by field against the oldest entry.
// ----------------------------------------------------------------------------
module sbag_deal_monitor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [sbag_pkg::FUNC_W-1:0]   req_func,
   input  logic [sbag_pkg::SEED_W-1:0]   req_seed,
   input  logic [sbag_pkg::SEED_W-1:0]   req_entropy,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [sbag_pkg::SCENE_W-1:0]  rsp_scene,
   input  logic                          rsp_dealt,
   input  logic [sbag_pkg::REM_W-1:0]    rsp_remaining,
   output int                            fail_count,
   output int                            pending
);

   import sbag_pkg::*;

   localparam int BAG_SIZE = SCENE_COUNT_DEF;

   typedef struct packed {
      logic [SCENE_W-1:0] scene;
      logic               dealt;
      logic [REM_W-1:0]   remaining;
   } deal_rsp_type;

   deal_rsp_type       due_rsps[$];
   logic [SCENE_W-1:0] bag_order[BAG_SIZE];
   int                 deal_pos;
   logic [SCENE_W-1:0] recent_scene;
   logic               recent_scene_ok;
   int                 rsp_seen;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch on response %0d: %s got %0d want %0d",
               $realtime, rsp_seen, what, got, want);
      fail_count++;
   endtask

   function automatic logic [SEED_W-1:0] xorshift_next(input logic [SEED_W-1:0] cur);
      logic [SEED_W-1:0] v;
      v = (cur == '0) ? XS_ZERO_SUB : cur;
      v ^= v << XS_SHIFT_A;
      v ^= v >> XS_SHIFT_B;
      v ^= v << XS_SHIFT_C;
      return v;
   endfunction

   task automatic reshuffle_bag(input logic [SEED_W-1:0] seed,
                                input logic [SEED_W-1:0] entropy);
      logic [SEED_W-1:0]  gen;
      logic [SCENE_W-1:0] tmp;
      int                 pick;
      gen = (seed == '0) ? entropy : seed;
      for (int k = 0; k < BAG_SIZE; k++) bag_order[k] = SCENE_W'(k);
      for (int k = BAG_SIZE; k > 1; k--) begin
         gen  = xorshift_next(gen);
         pick = int'(gen % SEED_W'(k));
         tmp                 = bag_order[k - 1];
         bag_order[k - 1]    = bag_order[pick];
         bag_order[pick]     = tmp;
      end
      if (recent_scene_ok && bag_order[0] == recent_scene) begin
         tmp          = bag_order[0];
         bag_order[0] = bag_order[1];
         bag_order[1] = tmp;
      end
      deal_pos = 0;
   endtask

   task automatic predict_deal(input logic [FUNC_W-1:0] func,
                               input logic [SEED_W-1:0] seed,
                               input logic [SEED_W-1:0] entropy);
      deal_rsp_type r;
      r = '0;
      if (func == FUNC_SHUFFLE) begin
         reshuffle_bag(seed, entropy);
      end else begin
         if (deal_pos >= BAG_SIZE) reshuffle_bag(seed, entropy);
         r.scene         = bag_order[deal_pos];
         r.dealt         = 1'b1;
         recent_scene    = r.scene;
         recent_scene_ok = 1'b1;
         deal_pos++;
      end
      r.remaining = (deal_pos >= BAG_SIZE) ? '0 : REM_W'(BAG_SIZE - deal_pos);
      due_rsps.push_back(r);
   endtask

   always @(posedge clock) begin
      deal_rsp_type want;
      if (reset) begin
         due_rsps.delete();
         deal_pos        = BAG_SIZE;
         recent_scene    = '0;
         recent_scene_ok = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_rsps.size() == 0) begin
               report_mismatch("unexpected response, scene", rsp_scene, -1);
            end else begin
               want = due_rsps.pop_front();
               if (rsp_scene !== want.scene)
                  report_mismatch("scene", rsp_scene, want.scene);
               if (rsp_dealt !== want.dealt)
                  report_mismatch("dealt", rsp_dealt, want.dealt);
               if (rsp_remaining !== want.remaining)
                  report_mismatch("remaining", rsp_remaining, want.remaining);
            end
            rsp_seen++;
         end
         if (req_valid && !req_stall) predict_deal(req_func, req_seed, req_entropy);
      end
      pending = due_rsps.size();
   end

endmodule

// File: tb/sv/tb_shuffle_bag_no_repeat_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shuffle_bag_no_repeat_core
// Drives deal and reshuffle requests into the shuffle bag core with random
// gaps and random response back-pressure, including one long hold-off that
// fills the core. A directed opening covers zero seeds, all-ones words,
// bag exhaustion and reshuffles; the rest is random. The monitor predicts
// and checks every response; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_shuffle_bag_no_repeat_core;
   import sbag_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int LONG_HOLD    = 3000;
   localparam int CYCLE_LIMIT  = 5_000_000;
   localparam int DRAIN_TAIL   = 50;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic [FUNC_W-1:0]  req_func    = FUNC_DEAL;
   logic [SEED_W-1:0]  req_seed    = '0;
   logic [SEED_W-1:0]  req_entropy = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic [SCENE_W-1:0] rsp_scene;
   logic               rsp_dealt;
   logic [REM_W-1:0]   rsp_remaining;

   int fail_count;
   int pending;
   int cycle_count  = 0;
   bit calm         = 1'b0;
   bit long_hold_due = 1'b0;

   always #5 clock = ~clock;

   shuffle_bag_no_repeat_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_seed      (req_seed),
      .req_entropy   (req_entropy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_scene     (rsp_scene),
      .rsp_dealt     (rsp_dealt),
      .rsp_remaining (rsp_remaining)
   );

   sbag_deal_monitor i_deal_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_seed      (req_seed),
      .req_entropy   (req_entropy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_scene     (rsp_scene),
      .rsp_dealt     (rsp_dealt),
      .rsp_remaining (rsp_remaining),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(20, 80);
   endfunction

   task automatic offer(input logic [FUNC_W-1:0] func,
                        input logic [SEED_W-1:0] seed,
                        input logic [SEED_W-1:0] entropy);
      int gap;
      req_valid   <= 1'b1;
      req_func    <= func;
      req_seed    <= seed;
      req_entropy <= entropy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // response back-pressure
   initial begin
      bit stall_val;
      bit hold_done;
      int run_len;
      hold_done = 1'b0;
      forever begin
         if (long_hold_due && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            stall_val = !calm && ($urandom_range(0, 2) == 0);
            run_len   = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 3);
            rsp_stall <= stall_val;
            repeat (run_len) @(posedge clock);
         end
      end
   end

   initial begin
      logic [FUNC_W-1:0] func;
      logic [SEED_W-1:0] seed;
      logic [SEED_W-1:0] entropy;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty bag with all-zero seeding, then drain the whole bag
      offer(FUNC_DEAL, '0, '0);
      for (int k = 1; k < SCENE_COUNT_DEF; k++) offer(FUNC_DEAL, $urandom(), $urandom());
      offer(FUNC_DEAL, '0, '1);
      offer(FUNC_SHUFFLE, '1, '0);
      offer(FUNC_SHUFFLE, '0, '0);
      offer(FUNC_DEAL, 32'h1, '1);
      offer(FUNC_SHUFFLE, '0, '1);
      offer(FUNC_DEAL, '1, '1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
         if (n == 300) long_hold_due = 1'b1;
         func    = ($urandom_range(0, 19) == 0) ? FUNC_SHUFFLE : FUNC_DEAL;
         seed    = ($urandom_range(0, 3) == 0) ? '0 : $urandom();
         entropy = ($urandom_range(0, 15) == 0) ? '0 : $urandom();
         offer(func, seed, entropy);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
